// File: rtl/core/postfix_stack_evaluator_unit_assert.svh
// Assertion macros for the postfix evaluator checker file.
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pse_pkg.sv
// Types and constants shared by the postfix evaluator modules.
package pse_pkg;

    localparam int WORD_W = 32;

    // ASCII codes of the accepted characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_BADCHAR   = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } sym_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [2:0]               status;
    } res_item_t;

endpackage

// File: rtl/core/pse_divider.sv
// Radix-2 restoring divider, signed operands, quotient truncated toward zero.
module pse_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pse_pkg::WORD_W-1:0] dividend,
    input  logic [pse_pkg::WORD_W-1:0] divisor,
    output logic                      done,
    output logic [pse_pkg::WORD_W-1:0] quotient
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;

    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;
    logic              qbit;

    // Trial subtraction for one quotient bit
    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign qbit    = ~diff[WORD_W];

    // Load magnitudes on start, then retire one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
                dvs_reg  <= divisor[WORD_W-1] ? ('0 - divisor) : divisor;
                quo_reg  <= dividend[WORD_W-1] ? ('0 - dividend) : dividend;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restore the sign; the most negative quotient wraps onto itself
    assign done     = done_reg;
    assign quotient = neg_reg ? ('0 - quo_reg) : quo_reg;

endmodule

// File: rtl/core/postfix_stack_evaluator_unit.sv
// Top level of the postfix expression evaluator.
// Takes one ASCII character per transaction and evaluates the postfix expression on an
// operand stack held in a single synchronous memory (one write port, one registered read
// port); the top of the stack is mirrored in a register, so an operator reads only the
// second entry. A digit is pushed as it is accepted; + - and * take a memory read, then
// execute and write back, and / waits on the 32-step radix-2 divider before write back.
// A character flagged last then moves the result into the output register in a result
// state, waiting while that register still holds a result not yet taken. Errors
// (underflow, overflow, divide by zero, bad character) are sticky within an expression;
// the result then carries value 0 and the first error code. No clearing pass is needed
// after reset.
module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sym_valid,
    output logic               sym_ready,
    input  pse_pkg::sym_item_t sym_item,
    output logic               res_valid,
    input  logic               res_ready,
    output pse_pkg::res_item_t res_item
);
    import pse_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);
    localparam logic [DW-1:0] DEPTH_TWO  = DW'(2);

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_RESULT
    } state_t;

    state_t            state_reg;
    logic [DW-1:0]     depth_reg;
    status_t           err_reg;
    logic [WORD_W-1:0] tos_reg;
    op_t               op_reg;
    logic              last_reg;
    logic              res_valid_reg;
    res_item_t         res_item_reg;

    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    logic              accept;
    logic              is_digit;
    logic              is_op;
    op_t               dec_op;
    logic [7:0]        digit_low;
    logic [WORD_W-1:0] digit_val;
    logic              push_ok;
    logic              go_exec;
    status_t           idle_err;
    logic [DW-1:0]     depth_m2;
    logic [WORD_W-1:0] alu_res;
    logic              wb_fire;
    logic              div_start;
    logic              div_done;
    logic [WORD_W-1:0] div_quot;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    assign sym_ready = (state_reg == S_IDLE);
    assign accept    = sym_valid && sym_ready;

    // Decode the character
    assign is_digit  = (sym_item.symbol >= CH_ZERO) && (sym_item.symbol <= CH_NINE);
    assign digit_low = sym_item.symbol - CH_ZERO;
    assign digit_val = {{(WORD_W - 8){1'b0}}, digit_low};

    always_comb
    begin
        is_op  = 1'b1;
        dec_op = OP_ADD;
        unique case (sym_item.symbol)
            CH_PLUS:  dec_op = OP_ADD;
            CH_MINUS: dec_op = OP_SUB;
            CH_STAR:  dec_op = OP_MUL;
            CH_SLASH: dec_op = OP_DIV;
            default:  is_op  = 1'b0;
        endcase
    end

    // Classify the character against the current stack: push, error or operator
    always_comb
    begin
        idle_err = ST_OK;
        push_ok  = 1'b0;
        go_exec  = 1'b0;
        if (err_reg == ST_OK)
        begin
            priority if (is_digit)
            begin
                if (depth_reg == DEPTH_FULL)
                    idle_err = ST_OVERFLOW;
                else
                    push_ok = 1'b1;
            end
            else if (!is_op)
                idle_err = ST_BADCHAR;
            else if (depth_reg < DEPTH_TWO)
                idle_err = ST_UNDERFLOW;
            else if ((dec_op == OP_DIV) && (tos_reg == '0))
                idle_err = ST_DIVZERO;
            else
                go_exec = 1'b1;
        end
    end

    // Operand a comes from memory, operand b is the cached top
    always_comb
    begin
        unique case (op_reg)
            OP_ADD: alu_res = rd_data_reg + tos_reg;
            OP_SUB: alu_res = rd_data_reg - tos_reg;
            OP_MUL: alu_res = rd_data_reg * tos_reg;
            OP_DIV: alu_res = div_quot;
        endcase
    end

    assign depth_m2  = depth_reg - DEPTH_TWO;
    assign div_start = (state_reg == S_EXEC) && (op_reg == OP_DIV);
    assign wb_fire   = ((state_reg == S_EXEC) && (op_reg != OP_DIV)) ||
                       ((state_reg == S_DIV) && div_done);

    pse_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Memory write port: push a digit or write back an operator result
    assign wr_en   = (accept && push_ok) || wb_fire;
    assign wr_addr = wb_fire ? depth_m2[AW-1:0] : depth_reg[AW-1:0];
    assign wr_data = wb_fire ? alu_res : digit_val;

    // Stack memory; read the second entry while waiting for a character
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        if (state_reg == S_IDLE)
            rd_data_reg <= stack_mem[depth_m2[AW-1:0]];
    end

    // Sequencer, stack bookkeeping and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= ST_OK;
            tos_reg       <= '0;
            op_reg        <= OP_ADD;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            // Drop a taken result unless a new one is loaded in the same cycle
            if (res_valid_reg && res_ready && (state_reg != S_RESULT))
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= sym_item.last;
                        op_reg   <= dec_op;
                        if (push_ok)
                        begin
                            tos_reg   <= digit_val;
                            depth_reg <= depth_reg + 1'b1;
                        end
                        if (idle_err != ST_OK)
                            err_reg <= idle_err;
                        if (go_exec)
                            state_reg <= S_EXEC;
                        else if (sym_item.last)
                            state_reg <= S_RESULT;
                    end
                end
                S_EXEC:
                begin
                    if (op_reg == OP_DIV)
                        state_reg <= S_DIV;
                    else
                    begin
                        tos_reg   <= alu_res;
                        depth_reg <= depth_reg - 1'b1;
                        state_reg <= last_reg ? S_RESULT : S_IDLE;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        tos_reg   <= alu_res;
                        depth_reg <= depth_reg - 1'b1;
                        state_reg <= last_reg ? S_RESULT : S_IDLE;
                    end
                end
                S_RESULT:
                begin
                    // Hold until the output register is free, then clear for the next
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg <= 1'b1;
                        if (err_reg != ST_OK)
                        begin
                            res_item_reg.value  <= '0;
                            res_item_reg.status <= err_reg;
                        end
                        else if (depth_reg == '0)
                        begin
                            res_item_reg.value  <= '0;
                            res_item_reg.status <= ST_EMPTY;
                        end
                        else
                        begin
                            res_item_reg.value  <= signed'(tos_reg);
                            res_item_reg.status <= ST_OK;
                        end
                        depth_reg <= '0;
                        err_reg   <= ST_OK;
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

// File: rtl/core/pse_checker.sv
// Port-level checker for the postfix evaluator, bound to the top level.
`include "postfix_stack_evaluator_unit_assert.svh"

module pse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sym_valid,
    input logic               sym_ready,
    input pse_pkg::sym_item_t sym_item,
    input logic               res_valid,
    input logic               res_ready,
    input pse_pkg::res_item_t res_item
);
    import pse_pkg::*;

    // Hold a stalled result transaction
    `PSE_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_item), "result changed while stalled")

    // Keep the status within the defined codes
    `PSE_ASSERT_IMP(a_status_range, res_valid, res_item.status <= ST_EMPTY, "undefined status code")

    // Drive value 0 whenever the status is not ok
    `PSE_ASSERT_IMP(a_err_value, res_valid && (res_item.status != ST_OK), res_item.value == '0, "nonzero value with error status")

endmodule

bind postfix_stack_evaluator_unit pse_checker u_pse_checker (.*);
